// File: src/u8ld_pkg.sv
// Shared types and constants of the lenient UTF-8 decoder.
`timescale 1ns / 1ps

package u8ld_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int CLUSTER_WIDTH    = 32;
    localparam int CP_WIDTH         = 21;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } u8ld_in_t;

    typedef struct packed {
        logic [CP_WIDTH-1:0]      code_point;
        logic                     invalid;
        logic [CLUSTER_WIDTH-1:0] cluster;
        logic                     last_result;
    } u8ld_out_t;

endpackage

// File: src/u8ld_front.sv
// Front part: takes input bytes and tags each with its saturated text offset.
`timescale 1ns / 1ps

module u8ld_front
    import u8ld_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CLUSTER_WIDTH-1:0]  cfg_data,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  u8ld_in_t                  byte_data,
    input  logic                      q_full,
    output logic                      q_push,
    output logic [OFFSET_WIDTH+8:0]   q_wdata
);

    logic [CLUSTER_WIDTH-1:0]              base_reg;
    logic [OFFSET_WIDTH-1:0]               next_off_reg;
    logic [OFFSET_WIDTH-1:0]               next_off_next;
    logic                                  run_start_reg;
    logic                                  run_start_next;
    logic [OFFSET_WIDTH+CLUSTER_WIDTH-1:0] base_ext;
    logic [OFFSET_WIDTH-1:0]               base_sat;
    logic [OFFSET_WIDTH-1:0]               cur_off;

    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    always_comb
    begin
        base_ext = {{OFFSET_WIDTH{1'b0}}, base_reg};
        if (base_ext > {{CLUSTER_WIDTH{1'b0}}, {OFFSET_WIDTH{1'b1}}})
        begin
            base_sat = '1;
        end
        else
        begin
            base_sat = base_ext[OFFSET_WIDTH-1:0];
        end
        cur_off = run_start_reg ? base_sat : next_off_reg;
        if (cur_off != {OFFSET_WIDTH{1'b1}})
        begin
            next_off_next = cur_off + 1'b1;
        end
        else
        begin
            next_off_next = cur_off;
        end
        run_start_next = byte_data.last_byte;
    end

    assign q_wdata = {cur_off, byte_data.last_byte, byte_data.byte_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            next_off_reg  <= '0;
            run_start_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            if (q_push)
            begin
                next_off_reg  <= next_off_next;
                run_start_reg <= run_start_next;
            end
        end
    end

endmodule

// File: src/u8ld_fifo.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps

module u8ld_fifo
#(
    parameter int WIDTH = 41
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_pop;

    assign full   = (count_reg == 2'(DEPTH));
    assign valid  = (count_reg != 2'd0);
    assign rdata  = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: src/u8ld_back.sv
// Back part: holds pending bytes and emits one decoded or invalid result per cycle unless the output stalls.
`timescale 1ns / 1ps

module u8ld_back
    import u8ld_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  logic [OFFSET_WIDTH+8:0] q_rdata,
    output logic                    q_pop,
    output logic                    cp_valid,
    input  logic                    cp_stall,
    output u8ld_out_t               cp_data
);

    localparam logic [7:0] ASCII_MAX  = 8'h7f;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_TAG  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_TAG  = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_TAG  = 8'hf0;
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    typedef struct packed {
        logic                hit;
        logic                bad;
        logic [CP_WIDTH-1:0] cp;
        logic [2:0]          drop;
    } step_t;

    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        if (c <= ASCII_MAX)
        begin
            len = 3'd1;
        end
        else if ((c & LEAD2_MASK) == LEAD2_TAG)
        begin
            len = 3'd2;
        end
        else if ((c & LEAD3_MASK) == LEAD3_TAG)
        begin
            len = 3'd3;
        end
        else if ((c & LEAD4_MASK) == LEAD4_TAG)
        begin
            len = 3'd4;
        end
        else
        begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic step_t classify(input logic [3:0][7:0] b, input logic [2:0] cnt,
                                       input logic last);
        step_t               r;
        logic [2:0]          len;
        logic                broken;
        logic [CP_WIDTH-1:0] cp;
        r      = '0;
        len    = seq_len(b[0]);
        broken = 1'b0;
        for (int i = 1; i < 4; i++)
        begin
            if (i < int'(len) && i < int'(cnt) && (b[i] & CONT_MASK) != CONT_TAG)
            begin
                broken = 1'b1;
            end
        end
        unique case (len)
            3'd1:    cp = {14'd0, b[0][6:0]};
            3'd2:    cp = {10'd0, b[0][4:0], b[1][5:0]};
            3'd3:    cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            3'd4:    cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: cp = '0;
        endcase
        if (cnt == 3'd0)
        begin
            r.hit = 1'b0;
        end
        else if (len == 3'd0 || broken)
        begin
            r.hit  = 1'b1;
            r.bad  = 1'b1;
            r.drop = 3'd1;
        end
        else if (cnt >= len)
        begin
            r.hit  = 1'b1;
            r.cp   = cp;
            r.drop = len;
        end
        else if (last)
        begin
            r.hit  = 1'b1;
            r.bad  = 1'b1;
            r.drop = 3'd1;
        end
        return r;
    endfunction

    logic [3:0][7:0]                       hb_reg;
    logic [3:0][7:0]                       hb_next;
    logic [OFFSET_WIDTH-1:0]               ho_reg  [4];
    logic [OFFSET_WIDTH-1:0]               ho_next [4];
    logic [2:0]                            cnt_reg;
    logic [2:0]                            cnt_next;
    logic                                  active_reg;
    logic                                  active_next;
    logic                                  last_reg;
    logic                                  last_next;
    logic                                  cp_valid_reg;
    logic                                  cp_valid_next;
    u8ld_out_t                             cp_data_reg;
    u8ld_out_t                             cp_data_next;

    logic [7:0]                            head_byte;
    logic                                  head_last;
    logic [OFFSET_WIDTH-1:0]               head_off;
    logic [3:0][7:0]                       work_b;
    logic [OFFSET_WIDTH-1:0]               work_o [4];
    logic [2:0]                            work_cnt;
    logic                                  work_last;
    logic [3:0][7:0]                       post_b;
    logic [OFFSET_WIDTH-1:0]               post_o [4];
    logic [2:0]                            post_cnt;
    step_t                                 res;
    step_t                                 res_post;
    logic                                  out_free;
    logic                                  go;
    logic                                  emit;
    logic [OFFSET_WIDTH+CLUSTER_WIDTH-1:0] cl_ext;

    assign head_byte = q_rdata[7:0];
    assign head_last = q_rdata[8];
    assign head_off  = q_rdata[OFFSET_WIDTH+8:9];
    assign out_free  = !cp_valid_reg || !cp_stall;
    assign go        = out_free && (active_reg || q_valid);
    assign q_pop     = go && !active_reg;

    always_comb
    begin
        int idx;
        work_b = hb_reg;
        for (int i = 0; i < 4; i++)
        begin
            work_o[i] = ho_reg[i];
        end
        work_cnt  = cnt_reg;
        work_last = last_reg;
        if (!active_reg)
        begin
            work_b[cnt_reg[1:0]] = head_byte;
            work_o[cnt_reg[1:0]] = head_off;
            work_cnt             = cnt_reg + 3'd1;
            work_last            = head_last;
        end

        res = classify(work_b, work_cnt, work_last);

        for (int i = 0; i < 4; i++)
        begin
            idx = i + int'(res.drop);
            if (idx < 4)
            begin
                post_b[i] = work_b[idx[1:0]];
                post_o[i] = work_o[idx[1:0]];
            end
            else
            begin
                post_b[i] = '0;
                post_o[i] = '0;
            end
        end
        post_cnt = work_cnt - res.drop;
        res_post = classify(post_b, post_cnt, work_last);

        emit = go && res.hit;

        hb_next     = hb_reg;
        for (int i = 0; i < 4; i++)
        begin
            ho_next[i] = ho_reg[i];
        end
        cnt_next    = cnt_reg;
        active_next = active_reg;
        last_next   = last_reg;
        if (go)
        begin
            last_next = work_last;
            if (res.hit)
            begin
                hb_next     = post_b;
                for (int i = 0; i < 4; i++)
                begin
                    ho_next[i] = post_o[i];
                end
                cnt_next    = post_cnt;
                active_next = res_post.hit;
            end
            else
            begin
                hb_next     = work_b;
                for (int i = 0; i < 4; i++)
                begin
                    ho_next[i] = work_o[i];
                end
                cnt_next    = work_cnt;
                active_next = 1'b0;
            end
        end

        cl_ext                   = {{CLUSTER_WIDTH{1'b0}}, work_o[0]};
        cp_data_next             = cp_data_reg;
        cp_valid_next            = cp_valid_reg && cp_stall;
        if (emit)
        begin
            cp_valid_next            = 1'b1;
            cp_data_next.code_point  = res.cp;
            cp_data_next.invalid     = res.bad;
            cp_data_next.cluster     = cl_ext[CLUSTER_WIDTH-1:0];
            cp_data_next.last_result = !res_post.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        hb_reg      <= hb_next;
        ho_reg      <= ho_next;
        last_reg    <= last_next;
        cp_data_reg <= cp_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= 3'd0;
            active_reg   <= 1'b0;
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            active_reg   <= active_next;
            cp_valid_reg <= cp_valid_next;
        end
    end

    assign cp_valid = cp_valid_reg;
    assign cp_data  = cp_data_reg;

endmodule

// File: src/utf8_lenient_decoder.sv
// Top level of the lenient UTF-8 decoder.
`timescale 1ns / 1ps
// Usage:
// The byte channel (byte_valid, byte_stall, byte_data) takes one UTF-8 byte per
// transfer, with last_byte set on the final byte of a text run. The cp channel
// (cp_valid, cp_stall, cp_data) gives decoded code points, each tagged with the
// text offset of its lead byte, and with last_result set on the final result
// that an input byte causes. Bad sequences give an invalid result for the lead
// byte, after which the following bytes are decoded again.
// cfg_we with cfg_data writes the base offset of the first byte of a run; write
// it only while the block is idle.
// An accepted byte passes through the queue and the output register before its first result is offered.
// The back part emits one result per cycle unless the receiver stalls; the block
// sustains one byte per cycle while each byte gives at most one result, and a
// byte that ends a broken sequence gives up to four results before the next byte is taken.
// A two-entry queue separates intake from decoding, so input keeps flowing while
// a result waits. When the receiver stalls, the output register holds its
// result, the queue fills and byte_stall rises.
// Reset empties the queue and the pending bytes and sets the base offset to zero.

module utf8_lenient_decoder
    import u8ld_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CLUSTER_WIDTH-1:0] cfg_data,
    input  logic                     byte_valid,
    output logic                     byte_stall,
    input  u8ld_in_t                 byte_data,
    output logic                     cp_valid,
    input  logic                     cp_stall,
    output u8ld_out_t                cp_data
);

    localparam int Q_WIDTH = OFFSET_WIDTH + 9;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic [Q_WIDTH-1:0] q_wdata;
    logic [Q_WIDTH-1:0] q_rdata;

    u8ld_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    u8ld_fifo #(.WIDTH(Q_WIDTH)) queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    u8ld_back #(.OFFSET_WIDTH(OFFSET_WIDTH)) back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .cp_valid (cp_valid),
        .cp_stall (cp_stall),
        .cp_data  (cp_data)
    );

endmodule

// File: src/u8ld_checker.sv
// Port-level assertions of the lenient UTF-8 decoder and their binding.
`timescale 1ns / 1ps

module u8ld_checker
    import u8ld_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cp_valid,
    input logic      cp_stall,
    input u8ld_out_t cp_data
);

    // No result is offered on the first edge after reset is released.
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !cp_valid)
        else $error("result offered right after reset");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cp_valid && cp_data.invalid) |-> (cp_data.code_point == '0))
        else $error("invalid result carries a code point");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cp_valid && cp_stall) |=> (cp_valid && $stable(cp_data)))
        else $error("stalled result changed");

    // Further results of the same byte follow without a gap.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (cp_valid && !cp_stall && !cp_data.last_result) |=> cp_valid)
        else $error("gap inside the results of one byte");

endmodule

bind utf8_lenient_decoder u8ld_checker checker_inst (.*);
